@@ design/bounded_set_store_engine_defines.svh @@
// Assertion macros used by the set store datapath.
`ifndef BOUNDED_SET_STORE_ENGINE_DEFINES_SVH
`define BOUNDED_SET_STORE_ENGINE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BSSE_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check a condition in the cycle after a trigger.
`define BSSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bsse_pkg.sv @@
// Types, codes and constants shared by the set store modules.
`default_nettype none
package bsse_pkg;
    localparam int MAX_SETS_DEF = 8;
    localparam int SET_SIZE_DEF = 16;
    localparam int CMD_W        = 3;
    localparam int IDX_W        = 3;
    localparam int WORD_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int SIU_W        = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_UNION  = 3'd3,
        CMD_ISECT  = 3'd4,
        CMD_READ   = 3'd5,
        CMD_SEARCH = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 3'd0,
        STS_BADIDX = 3'd1,
        STS_FULL   = 3'd2,
        STS_OVER   = 3'd3,
        STS_DUP    = 3'd4,
        STS_FEW    = 3'd5,
        STS_ENDED  = 3'd6,
        STS_NONE   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        ITEM_ZERO  = 2'd0,
        ITEM_RDATA = 2'd1,
        ITEM_INDEX = 2'd2
    } item_sel_t;

    typedef struct packed {
        logic      load_value;
        logic      load_elem_value;
        logic      load_elem_rdata;
        logic      mem_rd;
        logic      mem_wr;
        logic      wsel_rdata;
        logic      size_wr;
        logic      total_inc;
        logic      total_dec;
        logic      out_load;
        item_sel_t isel;
        status_t   st;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic match;
        logic value_zero;
        logic out_free;
    } dp_stat_t;
endpackage
`default_nettype wire

@@ design/bsse_in_if.sv @@
// Command channel: valid/ready handshake with the command fields.
`default_nettype none
interface bsse_in_if;
    logic                valid;
    logic                ready;
    logic [2:0]          cmd;
    logic [2:0]          set_a;
    logic [2:0]          set_b;
    logic signed [31:0]  value;

    modport source (output valid, output cmd, output set_a, output set_b, output value,
                    input ready);
    modport sink (input valid, input cmd, input set_a, input set_b, input value,
                  output ready);
endinterface
`default_nettype wire

@@ design/bsse_out_if.sv @@
// Result channel: valid/ready handshake with the result fields.
`default_nettype none
interface bsse_out_if;
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic signed [31:0]  item;
    logic [3:0]          sets_in_use;
    logic                last;

    modport source (output valid, output status, output item, output sets_in_use,
                    output last, input ready);
    modport sink (input valid, input status, input item, input sets_in_use,
                  input last, output ready);
endinterface
`default_nettype wire

@@ design/bsse_datapath.sv @@
// Set store datapath: element memory, set sizes, set count and result register.
`default_nettype none
`include "bounded_set_store_engine_defines.svh"
module bsse_datapath #(
    parameter int MAX_SETS = bsse_pkg::MAX_SETS_DEF,
    parameter int SET_SIZE = bsse_pkg::SET_SIZE_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire logic signed [31:0]              value,
    bsse_out_if.source                           rsp,
    input  wire bsse_pkg::dp_cmd_t               dc,
    output bsse_pkg::dp_stat_t                   stat,
    input  wire logic [$clog2(MAX_SETS)-1:0]     rd_row,
    input  wire logic [$clog2(SET_SIZE)-1:0]     rd_col,
    input  wire logic [$clog2(MAX_SETS)-1:0]     wr_row,
    input  wire logic [$clog2(SET_SIZE)-1:0]     wr_col,
    input  wire logic [$clog2(MAX_SETS)-1:0]     size_idx,
    input  wire logic [$clog2(MAX_SETS)-1:0]     size_wr_idx,
    input  wire logic [$clog2(SET_SIZE+1)-1:0]   size_wdata,
    input  wire logic [$clog2(MAX_SETS+1)-1:0]   eidx,
    output logic [$clog2(MAX_SETS+1)-1:0]        total,
    output logic [$clog2(SET_SIZE+1)-1:0]        size_rd
);
    import bsse_pkg::*;

    localparam int DEPTH = MAX_SETS * SET_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_SETS + 1);
    localparam int NW    = $clog2(SET_SIZE + 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(SET_SIZE);

    logic [WORD_W-1:0]        mem [DEPTH];
    logic [WORD_W-1:0]        rdata_reg;
    logic [WORD_W-1:0]        value_reg;
    logic [WORD_W-1:0]        elem_reg;
    logic [NW-1:0]            sizes_reg [MAX_SETS];
    logic [TW-1:0]            total_reg;
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [WORD_W-1:0]        out_item_reg;
    logic [SIU_W-1:0]         out_siu_reg;
    logic                     out_last_reg;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic [WORD_W-1:0]        wdata;
    logic [WORD_W-1:0]        item_next;

    assign raddr = AW'(rd_row) * ROW_STRIDE + AW'(rd_col);
    assign waddr = AW'(wr_row) * ROW_STRIDE + AW'(wr_col);
    assign wdata = dc.wsel_rdata ? rdata_reg : elem_reg;

    always_ff @(posedge clk)
    begin
        if (dc.mem_wr)
        begin
            mem[waddr] <= wdata;
        end
        if (dc.mem_rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dc.load_value)
        begin
            value_reg <= value;
        end
        if (dc.load_elem_value)
        begin
            elem_reg <= value_reg;
        end
        else if (dc.load_elem_rdata)
        begin
            elem_reg <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_SETS; s++)
            begin
                sizes_reg[s] <= '0;
            end
            total_reg <= '0;
        end
        else
        begin
            if (dc.size_wr)
            begin
                sizes_reg[size_wr_idx] <= size_wdata;
            end
            if (dc.total_inc)
            begin
                total_reg <= total_reg + TW'(1);
            end
            else if (dc.total_dec)
            begin
                total_reg <= total_reg - TW'(1);
            end
        end
    end

    always_comb
    begin
        unique case (dc.isel)
            ITEM_RDATA: item_next = rdata_reg;
            ITEM_INDEX: item_next = WORD_W'(eidx);
            default:    item_next = '0;
        endcase
    end

    // Hold a result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dc.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dc.out_load)
        begin
            out_status_reg <= dc.st;
            out_item_reg   <= item_next;
            out_siu_reg    <= SIU_W'(total_reg);
            out_last_reg   <= dc.last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.item        = out_item_reg;
    assign rsp.sets_in_use = out_siu_reg;
    assign rsp.last        = out_last_reg;

    assign total           = total_reg;
    assign size_rd         = sizes_reg[size_idx];
    assign stat.match      = (rdata_reg == elem_reg);
    assign stat.value_zero = (value_reg == '0);
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    `BSSE_ASSERT(a_total_bound, total_reg <= TW'(MAX_SETS), "set count above maximum")
    `BSSE_ASSERT(a_load_free, !dc.out_load || !out_valid_reg || rsp.ready,
                 "result overwritten before transfer")
    `BSSE_ASSERT(a_waddr_range, !dc.mem_wr || (waddr <= AW'(DEPTH - 1)),
                 "element write outside store")
    `BSSE_ASSERT_NEXT(a_total_inc, dc.total_inc, total_reg == $past(total_reg) + TW'(1),
                      "set count did not advance")
endmodule
`default_nettype wire

@@ design/bsse_ctrl.sv @@
// Set store controller: command decode and loop sequencing over the datapath.
`default_nettype none
module bsse_ctrl #(
    parameter int MAX_SETS = bsse_pkg::MAX_SETS_DEF,
    parameter int SET_SIZE = bsse_pkg::SET_SIZE_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    bsse_in_if.sink                              req,
    output bsse_pkg::dp_cmd_t                    dc,
    input  wire bsse_pkg::dp_stat_t              stat,
    output logic [$clog2(MAX_SETS)-1:0]          rd_row,
    output logic [$clog2(SET_SIZE)-1:0]          rd_col,
    output logic [$clog2(MAX_SETS)-1:0]          wr_row,
    output logic [$clog2(SET_SIZE)-1:0]          wr_col,
    output logic [$clog2(MAX_SETS)-1:0]          size_idx,
    output logic [$clog2(MAX_SETS)-1:0]          size_wr_idx,
    output logic [$clog2(SET_SIZE+1)-1:0]        size_wdata,
    output logic [$clog2(MAX_SETS+1)-1:0]        eidx,
    input  wire logic [$clog2(MAX_SETS+1)-1:0]   total,
    input  wire logic [$clog2(SET_SIZE+1)-1:0]   size_rd
);
    import bsse_pkg::*;

    localparam int RW = $clog2(MAX_SETS);
    localparam int CW = $clog2(SET_SIZE);
    localparam int TW = $clog2(MAX_SETS + 1);
    localparam int NW = $clog2(SET_SIZE + 1);
    localparam int XW = (TW > IDX_W) ? TW : IDX_W;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_SZA      = 15'b000000000000010,
        S_SZB      = 15'b000000000000100,
        S_DECIDE   = 15'b000000000001000,
        S_OUT_RD   = 15'b000000000010000,
        S_OUT_LD   = 15'b000000000100000,
        S_SC_RD    = 15'b000000001000000,
        S_SC_CMP   = 15'b000000010000000,
        S_RESOLVE  = 15'b000000100000000,
        S_FIN_SET  = 15'b000001000000000,
        S_REM_ROW  = 15'b000010000000000,
        S_COPY_RD  = 15'b000100000000000,
        S_COPY_WR  = 15'b001000000000000,
        S_SRCH_ROW = 15'b010000000000000,
        S_READ_RD  = 15'b100000000000000
    } state_t;

    // The emit step has no state code; keep it in emit_reg, a separate register bit.
    typedef enum logic [1:0] {
        PH_COPY_A  = 2'd0,
        PH_MERGE_B = 2'd1,
        PH_ISECT   = 2'd2
    } phase_t;

    state_t             state_reg, state_next;
    logic               emit_reg, emit_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [NW-1:0]      sa_reg, sa_next, sb_reg, sb_next;
    logic [NW-1:0]      lim_reg, lim_next, j_reg, j_next, m_reg, m_next;
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [TW-1:0]      i_reg, i_next, pend_i_reg, pend_i_next, eidx_reg, eidx_next;
    logic [RW-1:0]      tgt_reg, tgt_next;
    phase_t             ph_reg, ph_next;
    logic               found_reg, found_next, pend_v_reg, pend_v_next;
    status_t            st_reg, st_next;
    logic               last_reg, last_next;
    item_sel_t          isel_reg, isel_next;

    logic               a_bad, b_bad, append;
    logic [RW-1:0]      a_row, b_row, n_row, src_row;
    logic [NW-1:0]      src_len;

    assign a_row   = RW'(a_reg);
    assign b_row   = RW'(b_reg);
    assign n_row   = RW'(total);
    assign a_bad   = XW'(a_reg) >= XW'(total);
    assign b_bad   = XW'(b_reg) >= XW'(total);
    assign src_row = (ph_reg == PH_MERGE_B) ? b_row : a_row;
    assign src_len = (ph_reg == PH_MERGE_B) ? sb_reg : sa_reg;
    assign append  = (ph_reg == PH_ISECT) ? found_reg : !found_reg;
    assign eidx    = eidx_reg;

    always_comb
    begin
        state_next  = state_reg;
        emit_next   = emit_reg;
        cmd_next    = cmd_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        lim_next    = lim_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        pend_i_next = pend_i_reg;
        eidx_next   = eidx_reg;
        tgt_next    = tgt_reg;
        ph_next     = ph_reg;
        found_next  = found_reg;
        pend_v_next = pend_v_reg;
        st_next     = st_reg;
        last_next   = last_reg;
        isel_next   = isel_reg;

        dc          = '0;
        dc.st       = st_reg;
        dc.last     = last_reg;
        dc.isel     = isel_reg;
        req.ready   = 1'b0;
        rd_row      = src_row;
        rd_col      = CW'(j_reg);
        wr_row      = n_row;
        wr_col      = CW'(cnt_reg);
        size_idx    = a_row;
        size_wr_idx = n_row;
        size_wdata  = cnt_reg;

        if (emit_reg)
        begin
            if (stat.out_free)
            begin
                dc.out_load = 1'b1;
                emit_next   = 1'b0;
                if (last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (cmd_reg == CMD_READ)
                begin
                    state_next = S_READ_RD;
                end
                else
                begin
                    state_next = S_SRCH_ROW;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    req.ready = 1'b1;
                    if (req.valid)
                    begin
                        cmd_next      = cmd_t'(req.cmd);
                        a_next        = req.set_a;
                        b_next        = req.set_b;
                        dc.load_value = 1'b1;
                        state_next    = S_SZA;
                    end
                end
                S_SZA:
                begin
                    size_idx   = a_row;
                    sa_next    = size_rd;
                    state_next = S_SZB;
                end
                S_SZB:
                begin
                    size_idx   = b_row;
                    sb_next    = size_rd;
                    state_next = S_DECIDE;
                end
                S_DECIDE:
                begin
                    last_next = 1'b1;
                    isel_next = ITEM_ZERO;
                    st_next   = STS_OK;
                    emit_next = 1'b1;
                    unique case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (total >= TW'(MAX_SETS))
                            begin
                                st_next = STS_FULL;
                            end
                            else
                            begin
                                dc.total_inc = 1'b1;
                            end
                        end
                        CMD_INSERT:
                        begin
                            priority if (a_bad)
                            begin
                                st_next = STS_BADIDX;
                            end
                            else if (stat.value_zero)
                            begin
                                st_next = STS_ENDED;
                            end
                            else if (sa_reg >= NW'(SET_SIZE))
                            begin
                                st_next = STS_OVER;
                            end
                            else
                            begin
                                emit_next          = 1'b0;
                                dc.load_elem_value = 1'b1;
                                tgt_next           = a_row;
                                lim_next           = sa_reg;
                                m_next             = '0;
                                state_next         = S_SC_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (a_bad)
                            begin
                                st_next = STS_BADIDX;
                            end
                            else
                            begin
                                emit_next  = 1'b0;
                                i_next     = TW'(a_reg);
                                state_next = S_REM_ROW;
                            end
                        end
                        CMD_UNION, CMD_ISECT:
                        begin
                            priority if (total >= TW'(MAX_SETS))
                            begin
                                st_next = STS_FULL;
                            end
                            else if (total < TW'(2))
                            begin
                                st_next = STS_FEW;
                            end
                            else if (a_bad || b_bad)
                            begin
                                st_next = STS_BADIDX;
                            end
                            else if ((cmd_reg == CMD_UNION) &&
                                     ((NW+1)'(sa_reg) + (NW+1)'(sb_reg) > (NW+1)'(SET_SIZE)))
                            begin
                                st_next = STS_OVER;
                            end
                            else
                            begin
                                emit_next  = 1'b0;
                                cnt_next   = '0;
                                j_next     = '0;
                                ph_next    = (cmd_reg == CMD_UNION) ? PH_COPY_A : PH_ISECT;
                                state_next = S_OUT_RD;
                            end
                        end
                        CMD_READ:
                        begin
                            if (a_bad)
                            begin
                                st_next = STS_BADIDX;
                            end
                            else if (sa_reg == '0)
                            begin
                                st_next = STS_NONE;
                            end
                            else
                            begin
                                emit_next  = 1'b0;
                                j_next     = '0;
                                state_next = S_READ_RD;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (stat.value_zero)
                            begin
                                st_next = STS_NONE;
                            end
                            else
                            begin
                                emit_next          = 1'b0;
                                dc.load_elem_value = 1'b1;
                                i_next             = '0;
                                pend_v_next        = 1'b0;
                                state_next         = S_SRCH_ROW;
                            end
                        end
                        default:
                        begin
                            // drop an unknown command without a result
                            emit_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                    endcase
                end
                S_OUT_RD:
                begin
                    if (j_reg < src_len)
                    begin
                        dc.mem_rd  = 1'b1;
                        rd_row     = src_row;
                        rd_col     = CW'(j_reg);
                        state_next = S_OUT_LD;
                    end
                    else if (ph_reg == PH_COPY_A)
                    begin
                        ph_next = PH_MERGE_B;
                        j_next  = '0;
                    end
                    else
                    begin
                        state_next = S_FIN_SET;
                    end
                end
                S_OUT_LD:
                begin
                    dc.load_elem_rdata = 1'b1;
                    m_next             = '0;
                    unique case (ph_reg)
                        PH_COPY_A:  lim_next = '0;
                        PH_MERGE_B: lim_next = cnt_reg;
                        default:    lim_next = sb_reg;
                    endcase
                    tgt_next   = (ph_reg == PH_ISECT) ? b_row : n_row;
                    state_next = S_SC_RD;
                end
                S_SC_RD:
                begin
                    if (m_reg < lim_reg)
                    begin
                        dc.mem_rd  = 1'b1;
                        rd_row     = tgt_reg;
                        rd_col     = CW'(m_reg);
                        state_next = S_SC_CMP;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        state_next = S_RESOLVE;
                    end
                end
                S_SC_CMP:
                begin
                    if (stat.match)
                    begin
                        found_next = 1'b1;
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        m_next     = m_reg + NW'(1);
                        state_next = S_SC_RD;
                    end
                end
                S_RESOLVE:
                begin
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            last_next = 1'b1;
                            isel_next = ITEM_ZERO;
                            emit_next = 1'b1;
                            if (found_reg)
                            begin
                                st_next = STS_DUP;
                            end
                            else
                            begin
                                st_next     = STS_OK;
                                dc.mem_wr   = 1'b1;
                                wr_row      = a_row;
                                wr_col      = CW'(sa_reg);
                                dc.size_wr  = 1'b1;
                                size_wr_idx = a_row;
                                size_wdata  = sa_reg + NW'(1);
                            end
                        end
                        CMD_SEARCH:
                        begin
                            i_next     = i_reg + TW'(1);
                            state_next = S_SRCH_ROW;
                            if (found_reg)
                            begin
                                pend_v_next = 1'b1;
                                pend_i_next = i_reg;
                                if (pend_v_reg)
                                begin
                                    // flush the earlier hit; it is not the final one
                                    eidx_next = pend_i_reg;
                                    st_next   = STS_OK;
                                    last_next = 1'b0;
                                    isel_next = ITEM_INDEX;
                                    emit_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (append)
                            begin
                                dc.mem_wr = 1'b1;
                                wr_row    = n_row;
                                wr_col    = CW'(cnt_reg);
                                cnt_next  = cnt_reg + NW'(1);
                            end
                            j_next     = j_reg + NW'(1);
                            state_next = S_OUT_RD;
                        end
                    endcase
                end
                S_FIN_SET:
                begin
                    dc.size_wr   = 1'b1;
                    size_wr_idx  = n_row;
                    size_wdata   = cnt_reg;
                    dc.total_inc = 1'b1;
                    st_next      = STS_OK;
                    last_next    = 1'b1;
                    isel_next    = ITEM_ZERO;
                    emit_next    = 1'b1;
                end
                S_REM_ROW:
                begin
                    if ((i_reg + TW'(1)) < total)
                    begin
                        j_next     = '0;
                        state_next = S_COPY_RD;
                    end
                    else
                    begin
                        dc.size_wr   = 1'b1;
                        size_wr_idx  = RW'(total - TW'(1));
                        size_wdata   = '0;
                        dc.total_dec = 1'b1;
                        st_next      = STS_OK;
                        last_next    = 1'b1;
                        isel_next    = ITEM_ZERO;
                        emit_next    = 1'b1;
                    end
                end
                S_COPY_RD:
                begin
                    if (j_reg < NW'(SET_SIZE))
                    begin
                        dc.mem_rd  = 1'b1;
                        rd_row     = RW'(i_reg + TW'(1));
                        rd_col     = CW'(j_reg);
                        state_next = S_COPY_WR;
                    end
                    else
                    begin
                        // move the size down with the row
                        size_idx    = RW'(i_reg + TW'(1));
                        dc.size_wr  = 1'b1;
                        size_wr_idx = RW'(i_reg);
                        size_wdata  = size_rd;
                        i_next      = i_reg + TW'(1);
                        state_next  = S_REM_ROW;
                    end
                end
                S_COPY_WR:
                begin
                    dc.mem_wr     = 1'b1;
                    dc.wsel_rdata = 1'b1;
                    wr_row        = RW'(i_reg);
                    wr_col        = CW'(j_reg);
                    j_next        = j_reg + NW'(1);
                    state_next    = S_COPY_RD;
                end
                S_SRCH_ROW:
                begin
                    if (i_reg < total)
                    begin
                        size_idx   = RW'(i_reg);
                        lim_next   = size_rd;
                        tgt_next   = RW'(i_reg);
                        m_next     = '0;
                        state_next = S_SC_RD;
                    end
                    else
                    begin
                        last_next = 1'b1;
                        emit_next = 1'b1;
                        eidx_next = pend_i_reg;
                        if (pend_v_reg)
                        begin
                            st_next   = STS_OK;
                            isel_next = ITEM_INDEX;
                        end
                        else
                        begin
                            st_next   = STS_NONE;
                            isel_next = ITEM_ZERO;
                        end
                    end
                end
                S_READ_RD:
                begin
                    dc.mem_rd = 1'b1;
                    rd_row    = a_row;
                    rd_col    = CW'(j_reg);
                    st_next   = STS_OK;
                    isel_next = ITEM_RDATA;
                    last_next = ((j_reg + NW'(1)) == sa_reg);
                    j_next    = j_reg + NW'(1);
                    emit_next = 1'b1;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            emit_reg   <= 1'b0;
            cmd_reg    <= CMD_CREATE;
            a_reg      <= '0;
            b_reg      <= '0;
            sa_reg     <= '0;
            sb_reg     <= '0;
            lim_reg    <= '0;
            j_reg      <= '0;
            m_reg      <= '0;
            cnt_reg    <= '0;
            i_reg      <= '0;
            pend_i_reg <= '0;
            eidx_reg   <= '0;
            tgt_reg    <= '0;
            ph_reg     <= PH_COPY_A;
            found_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            st_reg     <= STS_OK;
            last_reg   <= 1'b0;
            isel_reg   <= ITEM_ZERO;
        end
        else
        begin
            state_reg  <= state_next;
            emit_reg   <= emit_next;
            cmd_reg    <= cmd_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            sa_reg     <= sa_next;
            sb_reg     <= sb_next;
            lim_reg    <= lim_next;
            j_reg      <= j_next;
            m_reg      <= m_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            pend_i_reg <= pend_i_next;
            eidx_reg   <= eidx_next;
            tgt_reg    <= tgt_next;
            ph_reg     <= ph_next;
            found_reg  <= found_next;
            pend_v_reg <= pend_v_next;
            st_reg     <= st_next;
            last_reg   <= last_next;
            isel_reg   <= isel_next;
        end
    end
endmodule
`default_nettype wire

@@ design/bounded_set_store_engine.sv @@
// Bounded set store: up to MAX_SETS sets of up to SET_SIZE distinct nonzero words.
// req carries one command (create, insert, remove, union, intersect, read, search)
// per transfer; rsp returns its results, the final one flagged by last.
// One command is in work at a time; req.ready is high only while the engine idles,
// and a result left in the rsp register does not hold back the next command.
// Create and every rejected command give their one result without using the element
// memory, as does remove of the last set; insert compares the value against each
// element already in the set and writes it only when no duplicate is found.
// Remove copies every word of each later set down a row through the element memory.
// Union and intersect compare each source element with n elements (B for intersect,
// the new set so far for the second pass of union); the first pass of union copies A
// without comparing. Read gives one result per element; search scans every stored
// element. The element memory (one read, one write port) sets pace.
// Reset empties every set at once: no clearing pass, first command at once.
// When the receiver stalls, the engine holds its pending result and waits.
`default_nettype none
module bounded_set_store_engine #(
    parameter int MAX_SETS = bsse_pkg::MAX_SETS_DEF,
    parameter int SET_SIZE = bsse_pkg::SET_SIZE_DEF
) (
    input wire          clk,
    input wire          rst_n,
    bsse_in_if.sink     req,
    bsse_out_if.source  rsp
);
    import bsse_pkg::*;

    localparam int RW = $clog2(MAX_SETS);
    localparam int CW = $clog2(SET_SIZE);
    localparam int TW = $clog2(MAX_SETS + 1);
    localparam int NW = $clog2(SET_SIZE + 1);

    dp_cmd_t          dc;
    dp_stat_t         stat;
    logic [RW-1:0]    rd_row, wr_row, size_idx, size_wr_idx;
    logic [CW-1:0]    rd_col, wr_col;
    logic [NW-1:0]    size_wdata, size_rd;
    logic [TW-1:0]    eidx, total;

    bsse_ctrl #(
        .MAX_SETS (MAX_SETS),
        .SET_SIZE (SET_SIZE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .dc          (dc),
        .stat        (stat),
        .rd_row      (rd_row),
        .rd_col      (rd_col),
        .wr_row      (wr_row),
        .wr_col      (wr_col),
        .size_idx    (size_idx),
        .size_wr_idx (size_wr_idx),
        .size_wdata  (size_wdata),
        .eidx        (eidx),
        .total       (total),
        .size_rd     (size_rd)
    );

    bsse_datapath #(
        .MAX_SETS (MAX_SETS),
        .SET_SIZE (SET_SIZE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (req.value),
        .rsp         (rsp),
        .dc          (dc),
        .stat        (stat),
        .rd_row      (rd_row),
        .rd_col      (rd_col),
        .wr_row      (wr_row),
        .wr_col      (wr_col),
        .size_idx    (size_idx),
        .size_wr_idx (size_wr_idx),
        .size_wdata  (size_wdata),
        .eidx        (eidx),
        .total       (total),
        .size_rd     (size_rd)
    );
endmodule
`default_nettype wire

@@ verif/bsse_tb_if.sv @@
// Interfaces are provided by the design; this file holds shared testbench types.
`timescale 1ns / 1ps
package bsse_tb_pkg;
    import bsse_pkg::*;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] item;
        logic [3:0]         sets_in_use;
        logic               last;
    } set_result_t;
endpackage

@@ verif/bsse_checker.sv @@
// Result predictor and scoreboard for the set store engine.
`timescale 1ns / 1ps
module bsse_checker
    import bsse_pkg::*;
    import bsse_tb_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int SET_SIZE = SET_SIZE_DEF
) (
    input  wire   clk,
    input  wire   rst_n,
    bsse_in_if    req,
    bsse_out_if   rsp,
    output int    fail_count,
    output int    pending,
    output int    results_seen,
    output int    cmds_seen
);
    logic signed [31:0] elems [MAX_SETS][SET_SIZE];
    int                 sizes [MAX_SETS];
    int                 total;
    set_result_t        expected_q [$];

    function automatic bit set_holds(int row, logic signed [31:0] v);
        for (int j = 0; j < sizes[row]; j++)
            if (elems[row][j] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_result(status_t st, logic signed [31:0] it, bit lst);
        set_result_t r;
        r.status      = st;
        r.item        = it;
        r.sets_in_use = total[3:0];
        r.last        = lst;
        expected_q.push_back(r);
    endfunction

    function automatic void append_elem(int row, logic signed [31:0] v);
        if (sizes[row] < SET_SIZE)
        begin
            elems[row][sizes[row]] = v;
            sizes[row]++;
        end
    endfunction

    function automatic void predict_command(logic [2:0] c, int a, int b,
                                            logic signed [31:0] v);
        int n;
        int k;
        case (c)
            CMD_CREATE:
            begin
                if (total >= MAX_SETS)
                    push_result(STS_FULL, 0, 1);
                else
                begin
                    total++;
                    push_result(STS_OK, 0, 1);
                end
            end
            CMD_INSERT:
            begin
                if (a >= total)                  push_result(STS_BADIDX, 0, 1);
                else if (v == 0)                 push_result(STS_ENDED, 0, 1);
                else if (sizes[a] >= SET_SIZE)   push_result(STS_OVER, 0, 1);
                else if (set_holds(a, v))        push_result(STS_DUP, 0, 1);
                else
                begin
                    append_elem(a, v);
                    push_result(STS_OK, 0, 1);
                end
            end
            CMD_REMOVE:
            begin
                if (a >= total)
                    push_result(STS_BADIDX, 0, 1);
                else
                begin
                    for (int i = a; i + 1 < total; i++)
                    begin
                        elems[i] = elems[i+1];
                        sizes[i] = sizes[i+1];
                    end
                    for (int j = 0; j < SET_SIZE; j++)
                        elems[total-1][j] = 0;
                    sizes[total-1] = 0;
                    total--;
                    push_result(STS_OK, 0, 1);
                end
            end
            CMD_UNION, CMD_ISECT:
            begin
                if (total >= MAX_SETS)                push_result(STS_FULL, 0, 1);
                else if (total < 2)                   push_result(STS_FEW, 0, 1);
                else if (a >= total || b >= total)    push_result(STS_BADIDX, 0, 1);
                else if (c == CMD_UNION && sizes[a] + sizes[b] > SET_SIZE)
                    push_result(STS_OVER, 0, 1);
                else
                begin
                    n = total;
                    sizes[n] = 0;
                    for (int j = 0; j < SET_SIZE; j++)
                        elems[n][j] = 0;
                    if (c == CMD_UNION)
                    begin
                        for (int j = 0; j < sizes[a]; j++)
                            append_elem(n, elems[a][j]);
                        for (int j = 0; j < sizes[b]; j++)
                            if (!set_holds(n, elems[b][j]))
                                append_elem(n, elems[b][j]);
                    end
                    else
                    begin
                        for (int j = 0; j < sizes[a]; j++)
                            if (set_holds(b, elems[a][j]))
                                append_elem(n, elems[a][j]);
                    end
                    total++;
                    push_result(STS_OK, 0, 1);
                end
            end
            CMD_READ:
            begin
                if (a >= total)          push_result(STS_BADIDX, 0, 1);
                else if (sizes[a] == 0)  push_result(STS_NONE, 0, 1);
                else
                    for (int j = 0; j < sizes[a]; j++)
                        push_result(STS_OK, elems[a][j], j + 1 == sizes[a]);
            end
            CMD_SEARCH:
            begin
                k = 0;
                for (int i = 0; i < total; i++)
                    if (v != 0 && set_holds(i, v))
                    begin
                        push_result(STS_OK, i, 0);
                        k++;
                    end
                if (k == 0)
                    push_result(STS_NONE, 0, 1);
                else
                    expected_q[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SETS; i++)
            begin
                sizes[i] = 0;
                for (int j = 0; j < SET_SIZE; j++)
                    elems[i][j] = 0;
            end
            total = 0;
            expected_q.delete();
            fail_count   = 0;
            results_seen = 0;
            cmds_seen    = 0;
        end
        else
        begin
            // check results before predicting a new command in the same edge
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result status=%0d item=%0d", $realtime,
                                 rsp.status, rsp.item);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (rsp.status !== exp_r.status || rsp.item !== exp_r.item ||
                        rsp.sets_in_use !== exp_r.sets_in_use || rsp.last !== exp_r.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp st=%0d it=%0d n=%0d l=%0d got st=%0d it=%0d n=%0d l=%0d",
                                     $realtime, exp_r.status, exp_r.item, exp_r.sets_in_use,
                                     exp_r.last, rsp.status, rsp.item, rsp.sets_in_use,
                                     rsp.last);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                cmds_seen++;
                predict_command(req.cmd, req.set_a, req.set_b, req.value);
            end
        end
        pending = expected_q.size();
    end
endmodule

@@ verif/testbench.sv @@
// Stimulus and verdict for the set store engine testbench.
`timescale 1ns / 1ps
module testbench;
    import bsse_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   cmds_seen;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off_cycles = 0;
    logic signed [31:0] pool [12];

    bsse_in_if  req ();
    bsse_out_if rsp ();

    bounded_set_store_engine u_top (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    bsse_checker u_checker (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .fail_count(fail_count),
        .pending(pending), .results_seen(results_seen), .cmds_seen(cmds_seen));

    always #2 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.cmd   = CMD_CREATE;
        req.set_a = '0;
        req.set_b = '0;
        req.value = '0;
        rsp.ready = 1'b0;
    end

    // receiver: random stall, or a long counted hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            rsp.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high after a transfer until the next command or an idle cycle
    task automatic send_cmd(cmd_t c, int a, int b, logic signed [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= c;
        req.set_a <= a[2:0];
        req.set_b <= b[2:0];
        req.value <= v;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 0;
            default: return pool[$urandom_range(11)];
        endcase
    endfunction

    task automatic random_cmds(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 12)      send_cmd(CMD_CREATE, $urandom_range(7), 0, $urandom);
            else if (r < 50) send_cmd(CMD_INSERT, $urandom_range(7), 0, pick_value());
            else if (r < 58) send_cmd(CMD_REMOVE, $urandom_range(7), 0, 0);
            else if (r < 66) send_cmd(CMD_UNION, $urandom_range(7), $urandom_range(7), 0);
            else if (r < 74) send_cmd(CMD_ISECT, $urandom_range(7), $urandom_range(7), 0);
            else if (r < 86) send_cmd(CMD_READ, $urandom_range(7), 0, 0);
            else if (r < 98) send_cmd(CMD_SEARCH, 0, 0, pick_value());
            else             send_cmd(cmd_t'(3'd7), $urandom_range(7), 0, $urandom);
        end
    endtask

    initial
    begin
        pool[0] = 32'sh7FFFFFFF;
        pool[1] = 32'sh80000000;
        pool[2] = -1;
        pool[3] = 1;
        for (int i = 4; i < 12; i++)
            pool[i] = $urandom_range(20) + 2;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors on an empty store, then extremes and every command
        send_cmd(CMD_UNION, 0, 1, 0);
        send_cmd(CMD_INSERT, 0, 0, 5);
        send_cmd(CMD_READ, 0, 0, 0);
        send_cmd(CMD_REMOVE, 0, 0, 0);
        send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_ISECT, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0);
        send_cmd(CMD_INSERT, 0, 0, 32'sh7FFFFFFF);
        send_cmd(CMD_INSERT, 0, 0, 32'sh80000000);
        send_cmd(CMD_INSERT, 0, 0, 32'sh80000000);
        send_cmd(CMD_INSERT, 0, 0, 0);
        send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_INSERT, 1, 0, -1);
        send_cmd(CMD_INSERT, 1, 0, 32'sh7FFFFFFF);
        send_cmd(CMD_UNION, 0, 1, 0);
        send_cmd(CMD_ISECT, 0, 1, 0);
        send_cmd(CMD_ISECT, 0, 0, 0);
        send_cmd(CMD_UNION, 7, 1, 0);
        send_cmd(CMD_SEARCH, 0, 0, 32'sh7FFFFFFF);
        send_cmd(CMD_SEARCH, 0, 0, 0);
        send_cmd(CMD_READ, 2, 0, 0);
        send_cmd(CMD_REMOVE, 0, 0, 0);
        send_cmd(cmd_t'(3'd7), 0, 0, 0);
        drain();

        // fill set 0 to overflow, then fill the store
        for (int i = 0; i < 17; i++)
            send_cmd(CMD_INSERT, 0, 0, 100 + i);
        for (int i = 0; i < 7; i++)
            send_cmd(CMD_CREATE, 0, 0, 0);
        send_cmd(CMD_UNION, 0, 1, 0);
        send_cmd(CMD_READ, 0, 0, 0);
        drain();
        while (cmds_seen < 60)
            send_cmd(CMD_REMOVE, 0, 0, 0);
        drain();

        // random phases with varying idle and stall
        random_cmds(60);
        send_idle_pct = 45;
        random_cmds(60);
        send_idle_pct = 0;
        recv_stall_pct = 45;
        random_cmds(60);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        random_cmds(60);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        random_cmds(40);
        drain();
        random_cmds(40);
        drain();
        repeat (100) @(posedge clk);

        $display("Covered %0d commands and %0d results, including overflow, full store,",
                 cmds_seen, results_seen);
        $display("removals, unions, intersections, reads and searches under stalls.");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ bounded_set_store_engine.f @@
+incdir+design
design/bsse_pkg.sv
design/bsse_in_if.sv
design/bsse_out_if.sv
design/bsse_datapath.sv
design/bsse_ctrl.sv
design/bounded_set_store_engine.sv
verif/bsse_tb_if.sv
verif/bsse_checker.sv
verif/testbench.sv
